// ===== hw/rtl/hhrc_pkg.sv =====
package hhrc_pkg;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_SMOOTHING_GAIN    = 3'd0;
    localparam t_cfg_index CFG_PROPORTIONAL_GAIN = 3'd1;
    localparam t_cfg_index CFG_DEADZONE_DEGREES  = 3'd2;
    localparam t_cfg_index CFG_RUDDER_LOW_LIMIT  = 3'd3;
    localparam t_cfg_index CFG_RUDDER_HIGH_LIMIT = 3'd4;

    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] RST_SMOOTHING_GAIN    = 16'd655;
    localparam logic [7:0]  RST_PROPORTIONAL_GAIN = 8'd40;
    localparam logic [7:0]  RST_DEADZONE_DEGREES  = 8'd2;
    localparam logic [7:0]  RST_RUDDER_LOW_LIMIT  = 8'd20;
    localparam logic [7:0]  RST_RUDDER_HIGH_LIMIT = 8'd170;

    // Sample format: degrees with 7 fraction bits
    localparam int          SAMPLE_FRAC_BITS  = 7;
    localparam logic [15:0] SAMPLE_FULL_TURN  = 16'd46080;

    localparam int GAIN_SHIFT = 16;
    localparam int KP_SHIFT   = 4;

    // Heading error after wrapping lies in -180..180
    localparam int ERR_W = 10;
    // Scaled rudder angle before clamping
    localparam int ANG_W = 14;

    localparam logic signed [ANG_W-1:0] ANGLE_CENTRE = 14'sd90;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX    = 14'sd180;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIFF = 7'b0000010,
        S_STEP = 7'b0000100,
        S_UPD  = 7'b0001000,
        S_ERR  = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_ANG  = 7'b1000000
    } t_state;

endpackage

// ===== hw/rtl/heading_hold_rudder_controller.sv =====
// Heading-hold rudder controller. Each input transfer brings a compass sample (degrees, 7
// fraction bits), a flag that marks the sample as a number, and a target heading in whole
// degrees. Valid samples feed an exponential moving-average filter held with
// FILTER_FRACTION_BITS fraction bits (the first valid sample loads it); the filtered heading,
// truncated to whole degrees, is compared with the target and the error is wrapped into
// -180..180. An error whose magnitude is below deadzone_degrees produces no output transfer;
// otherwise the rudder angle 90 + error * proportional_gain / 16 (truncated toward zero) is
// clamped to 0..180, then to the high limit and last to the low limit, and sent together with
// the filtered heading. One signed multiplier is shared by the filter step and the rudder
// gain, so an item occupies the block for a sequence of cycles and o_stall stays high until
// it is done: the difference, then the filter step and update when the filter moves, the
// error, then the gain product and the rudder angle when a result is produced. A result
// that is still waiting on a stalled output holds the last step of the next item until it
// has gone. Configuration writes are taken at any edge with i_cfg_wr_en high and should
// only be issued while the block is idle.
module heading_hold_rudder_controller
    import hhrc_pkg::*;
#(
    parameter int FILTER_FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_heading_sample,
    input  logic                  i_sample_valid,
    input  logic [8:0]            i_target_heading,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_rudder_angle,
    output logic [8:0]            o_filtered_heading
);

    localparam int FB = FILTER_FRACTION_BITS;
    localparam int HW = FB + 9;   // filter state, 0..360 degrees
    localparam int DW = FB + 10;  // wrapped difference, signed
    localparam int SW = FB + 11;  // filter plus step, signed
    localparam int PW = DW + 17;  // shared multiplier product

    localparam logic [HW-1:0]        FULL_TURN_H = {9'd360, {FB{1'b0}}};
    localparam logic signed [DW-1:0] HALF_TURN_D = {10'd180, {FB{1'b0}}};
    localparam logic signed [DW-1:0] FULL_TURN_D = {10'd360, {FB{1'b0}}};
    localparam logic signed [SW-1:0] FULL_TURN_S = {11'd360, {FB{1'b0}}};

    // ---------------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------------
    logic [15:0] r_smooth_gain;
    logic [7:0]  r_prop_gain;
    logic [7:0]  r_deadzone;
    logic [7:0]  r_rudder_lo;
    logic [7:0]  r_rudder_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_gain <= RST_SMOOTHING_GAIN;
            r_prop_gain   <= RST_PROPORTIONAL_GAIN;
            r_deadzone    <= RST_DEADZONE_DEGREES;
            r_rudder_lo   <= RST_RUDDER_LOW_LIMIT;
            r_rudder_hi   <= RST_RUDDER_HIGH_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SMOOTHING_GAIN:    r_smooth_gain <= i_cfg_data;
                CFG_PROPORTIONAL_GAIN: r_prop_gain   <= i_cfg_data[7:0];
                CFG_DEADZONE_DEGREES:  r_deadzone    <= i_cfg_data[7:0];
                CFG_RUDDER_LOW_LIMIT:  r_rudder_lo   <= i_cfg_data[7:0];
                CFG_RUDDER_HIGH_LIMIT: r_rudder_hi   <= i_cfg_data[7:0];
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------------------------
    t_state r_state, n_state;

    logic [15:0]                r_sample;     // sample already wrapped below 360 degrees
    logic                       r_sval;
    logic [8:0]                 r_target;
    logic [HW-1:0]              r_filt;
    logic                       r_started;
    logic signed [DW-1:0]       r_diff;
    logic signed [PW-1:0]       r_prod;
    logic signed [ERR_W-1:0]    r_err;
    logic [8:0]                 r_current;

    logic                       r_out_valid;
    logic [7:0]                 r_out_angle;
    logic [8:0]                 r_out_heading;

    logic in_xfer;
    logic out_free;

    assign in_xfer  = i_valid && !o_stall;
    // The output register can take a new result when empty or being emptied this cycle
    assign out_free = !r_out_valid || !i_stall;

    // ---------------------------------------------------------------------------------------
    // Filter difference: scale the sample to the filter format and wrap into -180..180
    // ---------------------------------------------------------------------------------------
    logic [HW-1:0]        sample_fine;
    logic signed [DW-1:0] diff_raw;
    logic signed [DW-1:0] diff_wrap;

    assign sample_fine = {r_sample, {(FB - SAMPLE_FRAC_BITS){1'b0}}};
    assign diff_raw    = $signed({1'b0, sample_fine}) - $signed({1'b0, r_filt});

    always_comb begin
        priority if (diff_raw > HALF_TURN_D) begin
            diff_wrap = diff_raw - FULL_TURN_D;
        end else if (diff_raw < -HALF_TURN_D) begin
            diff_wrap = diff_raw + FULL_TURN_D;
        end else begin
            diff_wrap = diff_raw;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Shared signed multiplier: filter step in S_STEP, rudder gain in S_MUL
    // ---------------------------------------------------------------------------------------
    logic signed [DW-1:0] mul_a;
    logic signed [16:0]   mul_b;
    logic signed [PW-1:0] mul_p;

    always_comb begin
        if (r_state == S_STEP) begin
            mul_a = r_diff;
            mul_b = $signed({1'b0, r_smooth_gain});
        end else begin
            mul_a = {{(DW - ERR_W){r_err[ERR_W-1]}}, r_err};
            mul_b = $signed({9'd0, r_prop_gain});
        end
    end

    assign mul_p = mul_a * mul_b;

    // ---------------------------------------------------------------------------------------
    // Filter update: step truncated toward zero, then one wrap into 0..360
    // ---------------------------------------------------------------------------------------
    logic signed [PW-1:0] step_round;
    logic signed [PW-1:0] step_shift;
    logic signed [SW-1:0] filt_sum;
    logic signed [SW-1:0] filt_wrap;

    // Bias negative products so the arithmetic shift rounds toward zero
    assign step_round = r_prod[PW-1] ? PW'((1 << GAIN_SHIFT) - 1) : '0;
    assign step_shift = (r_prod + step_round) >>> GAIN_SHIFT;
    assign filt_sum   = $signed({2'b00, r_filt}) + $signed(step_shift[SW-1:0]);

    always_comb begin
        priority if (filt_sum < 0) begin
            filt_wrap = filt_sum + FULL_TURN_S;
        end else if (filt_sum >= FULL_TURN_S) begin
            filt_wrap = filt_sum - FULL_TURN_S;
        end else begin
            filt_wrap = filt_sum;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Heading error in whole degrees and deadzone test
    // ---------------------------------------------------------------------------------------
    logic [8:0]         cur_deg;
    logic signed [10:0] err_raw;
    logic signed [10:0] err_wrap;
    logic signed [10:0] err_mag;
    logic               in_deadzone;

    assign cur_deg = r_filt[HW-1:FB];
    assign err_raw = $signed({2'b00, r_target}) - $signed({2'b00, cur_deg});

    always_comb begin
        priority if (err_raw > 11'sd180) begin
            err_wrap = err_raw - 11'sd360;
        end else if (err_raw < -11'sd180) begin
            err_wrap = err_raw + 11'sd360;
        end else begin
            err_wrap = err_raw;
        end
    end

    assign err_mag     = err_wrap[10] ? -err_wrap : err_wrap;
    assign in_deadzone = err_mag[7:0] < r_deadzone;

    // ---------------------------------------------------------------------------------------
    // Rudder angle: centre plus scaled error, then the clamp chain
    // ---------------------------------------------------------------------------------------
    logic signed [PW-1:0]    ang_round;
    logic signed [PW-1:0]    ang_shift;
    logic signed [ANG_W-1:0] ang_raw;
    logic signed [ANG_W-1:0] ang_clamp;

    assign ang_round = r_prod[PW-1] ? PW'((1 << KP_SHIFT) - 1) : '0;
    assign ang_shift = (r_prod + ang_round) >>> KP_SHIFT;
    assign ang_raw   = $signed(ang_shift[ANG_W-1:0]) + ANGLE_CENTRE;

    always_comb begin
        ang_clamp = ang_raw;
        if (ang_clamp > ANGLE_MAX) begin
            ang_clamp = ANGLE_MAX;
        end
        if (ang_clamp < 0) begin
            ang_clamp = '0;
        end
        // High limit first, low limit last so it wins when the limits cross
        if (ang_clamp > $signed({{(ANG_W - 8){1'b0}}, r_rudder_hi})) begin
            ang_clamp = $signed({{(ANG_W - 8){1'b0}}, r_rudder_hi});
        end
        if (ang_clamp < $signed({{(ANG_W - 8){1'b0}}, r_rudder_lo})) begin
            ang_clamp = $signed({{(ANG_W - 8){1'b0}}, r_rudder_lo});
        end
    end

    // ---------------------------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                // Invalid or first sample: no filter step to take
                if (r_sval && r_started) begin
                    n_state = S_STEP;
                end else begin
                    n_state = S_ERR;
                end
            end
            S_STEP: n_state = S_UPD;
            S_UPD:  n_state = S_ERR;
            S_ERR: begin
                n_state = in_deadzone ? S_IDLE : S_MUL;
            end
            S_MUL:  n_state = S_ANG;
            S_ANG: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Filter state and start flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt    <= '0;
            r_started <= 1'b0;
        end else if (r_state == S_DIFF && r_sval && !r_started) begin
            r_filt    <= sample_fine;
            r_started <= 1'b1;
        end else if (r_state == S_UPD) begin
            r_filt    <= filt_wrap[HW-1:0];
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            // Fold a sample at or above a full turn back once
            r_sample <= (i_heading_sample >= SAMPLE_FULL_TURN)
                        ? i_heading_sample - SAMPLE_FULL_TURN : i_heading_sample;
            r_sval   <= i_sample_valid;
            r_target <= i_target_heading;
        end
        if (r_state == S_DIFF) begin
            r_diff <= diff_wrap;
        end
        if (r_state == S_STEP || r_state == S_MUL) begin
            r_prod <= mul_p;
        end
        if (r_state == S_ERR) begin
            r_err     <= err_wrap[ERR_W-1:0];
            r_current <= cur_deg;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_ANG && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ANG && out_free) begin
            r_out_angle   <= ang_clamp[7:0];
            r_out_heading <= r_current;
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_rudder_angle     = r_out_angle;
    assign o_filtered_heading = r_out_heading;

    // ---------------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------------
    a_filter_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt < FULL_TURN_H)
        else $error("filtered heading left 0..360");

    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DIFF))
        else $error("accepted transfer did not start the sequencer");

    a_rudder_within_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_rudder_lo <= r_rudder_hi) |->
            (o_rudder_angle >= r_rudder_lo && o_rudder_angle <= r_rudder_hi))
        else $error("rudder angle outside the configured limits");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANG && !out_free) |=> (r_state == S_ANG && o_valid))
        else $error("result dropped while the output was stalled");

endmodule

// ===== tb/heading_hold_rudder_controller_tb.sv =====
module heading_hold_rudder_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hhrc_pkg::*;

    localparam int     FILTER_FRAC   = 16;
    localparam int     CLK_HALF      = 2;
    localparam int     RESET_CYCLES  = 5;
    localparam int     IDLE_PCT      = 24;
    // Leave room for the longest item still in flight after the last command
    localparam int     SETTLE_CYCLES = 16;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PRINT_LIMIT   = 40;
    localparam int     TIMEOUT_NS    = 2_000_000;
    localparam longint FINE_ONE      = longint'(1) << FILTER_FRAC;

    // Indexes past the last register: writes to them must be ignored
    localparam t_cfg_index CFG_SPARE_FIRST = 3'd5;
    localparam t_cfg_index CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [7:0] angle;
        logic [8:0] heading;
    } t_rudder_cmd;

    // Predicts the rudder commands of the controller and checks what comes out
    class rudder_command_checker;
        logic [15:0]            smoothing_gain;
        logic [7:0]             proportional_gain;
        logic [7:0]             deadzone;
        logic [7:0]             low_limit;
        logic [7:0]             high_limit;
        logic [8+FILTER_FRAC:0] heading_fine;
        bit                     filter_loaded;
        t_rudder_cmd            expected_cmds[$];
        int                     mismatches;

        function new();
            smoothing_gain    = RST_SMOOTHING_GAIN;
            proportional_gain = RST_PROPORTIONAL_GAIN;
            deadzone          = RST_DEADZONE_DEGREES;
            low_limit         = RST_RUDDER_LOW_LIMIT;
            high_limit        = RST_RUDDER_HIGH_LIMIT;
            heading_fine      = '0;
            filter_loaded     = 1'b0;
            mismatches        = 0;
        endfunction

        function int current_heading();
            return int'(heading_fine >> FILTER_FRAC);
        endfunction

        static function longint shift_toward_zero(longint prod, int sh);
            if (prod < 0)
                return -((-prod) >> sh);
            return prod >> sh;
        endfunction

        function void write_reg(t_cfg_index idx, logic [15:0] data);
            case (idx)
                CFG_SMOOTHING_GAIN:    smoothing_gain    = data;
                CFG_PROPORTIONAL_GAIN: proportional_gain = data[7:0];
                CFG_DEADZONE_DEGREES:  deadzone          = data[7:0];
                CFG_RUDDER_LOW_LIMIT:  low_limit         = data[7:0];
                CFG_RUDDER_HIGH_LIMIT: high_limit        = data[7:0];
                default: ;
            endcase
        endfunction

        function void accept_sample(logic [15:0] raw, logic is_number, logic [8:0] target);
            longint      sample;
            longint      fine;
            longint      diff;
            longint      err;
            longint      mag;
            longint      angle;
            t_rudder_cmd cmd;
            if (is_number) begin
                sample = longint'(raw);
                if (sample >= longint'(SAMPLE_FULL_TURN))
                    sample -= longint'(SAMPLE_FULL_TURN);
                sample = sample << (FILTER_FRAC - SAMPLE_FRAC_BITS);
                if (!filter_loaded) begin
                    fine          = sample;
                    filter_loaded = 1'b1;
                end else begin
                    fine = longint'(heading_fine);
                    diff = sample - fine;
                    if (diff > 180 * FINE_ONE)
                        diff -= 360 * FINE_ONE;
                    if (diff < -180 * FINE_ONE)
                        diff += 360 * FINE_ONE;
                    fine += shift_toward_zero(diff * longint'(smoothing_gain), GAIN_SHIFT);
                    if (fine < 0)
                        fine += 360 * FINE_ONE;
                    if (fine >= 360 * FINE_ONE)
                        fine -= 360 * FINE_ONE;
                end
                heading_fine = fine[8+FILTER_FRAC:0];
            end

            err = longint'(target) - longint'(current_heading());
            if (err > 180)
                err -= 360;
            if (err < -180)
                err += 360;
            mag = (err < 0) ? -err : err;
            if (mag < longint'(deadzone))
                return;

            angle = longint'(ANGLE_CENTRE)
                    + shift_toward_zero(err * longint'(proportional_gain), KP_SHIFT);
            if (angle > longint'(ANGLE_MAX))
                angle = longint'(ANGLE_MAX);
            if (angle < 0)
                angle = 0;
            if (angle > longint'(high_limit))
                angle = longint'(high_limit);
            if (angle < longint'(low_limit))
                angle = longint'(low_limit);
            cmd.angle   = angle[7:0];
            cmd.heading = 9'(current_heading());
            expected_cmds.push_back(cmd);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_command(logic [7:0] angle, logic [8:0] heading);
            t_rudder_cmd want;
            if (expected_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected command angle=%0d heading=%0d",
                                          angle, heading));
                return;
            end
            want = expected_cmds.pop_front();
            if (angle !== want.angle)
                report_mismatch($sformatf("rudder_angle %0d, want %0d", angle, want.angle));
            if (heading !== want.heading)
                report_mismatch($sformatf("filtered_heading %0d, want %0d",
                                          heading, want.heading));
        endtask
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_wr_en      = 1'b0;
    logic [2:0]  i_cfg_index      = '0;
    logic [15:0] i_cfg_data       = '0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [15:0] i_heading_sample = '0;
    logic        i_sample_valid   = 1'b0;
    logic [8:0]  i_target_heading = '0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [7:0]  o_rudder_angle;
    logic [8:0]  o_filtered_heading;

    // Idling controls, written by the stimulus only
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;
    bit hold_armed = 1'b0;

    // Owned by the receiver process
    bit hold_taken = 1'b0;
    int hold_left  = 0;

    rudder_command_checker cmd_check = new();

    heading_hold_rudder_controller #(
        .FILTER_FRACTION_BITS(FILTER_FRAC)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_heading_sample  (i_heading_sample),
        .i_sample_valid    (i_sample_valid),
        .i_target_heading  (i_target_heading),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_rudder_angle    (o_rudder_angle),
        .o_filtered_heading(o_filtered_heading)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Receiver: random back-pressure, a quiet mode, and one long hold-off so that the
    // block fills up and has to stall its input while the sender keeps offering.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_taken) begin
            i_stall    <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else if (recv_quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Sample both channels at the rising edge; note the input transfer before checking
    // the output one so a same-edge command always finds its expectation queued.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            cmd_check.accept_sample(i_heading_sample, i_sample_valid, i_target_heading);
        if (i_rst_n && o_valid && !i_stall)
            cmd_check.check_command(o_rudder_angle, o_filtered_heading);
    end

    // Offer one sample, idling first at random; return at the falling edge after the transfer
    task automatic send_sample(logic [15:0] raw, logic is_number, logic [8:0] target);
        if (!send_quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid          <= 1'b1;
        i_heading_sample <= raw;
        i_sample_valid   <= is_number;
        i_target_heading <= target;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // Target a fixed number of degrees away from the heading the filter holds now
    function automatic logic [8:0] heading_offset(int off);
        int t;
        t = cmd_check.current_heading() + off;
        t = ((t % 360) + 360) % 360;
        return t[8:0];
    endfunction

    // Drop valid, wait for every expected command, then let any silent item finish
    task automatic wait_idle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (cmd_check.expected_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        cmd_check.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Byte registers get random upper data bits, which the block must drop
    task automatic apply_settings(logic [15:0] gain, logic [7:0] kp, logic [7:0] dz,
                                  logic [7:0] lo, logic [7:0] hi);
        wait_idle();
        cfg_write(CFG_SMOOTHING_GAIN, gain);
        cfg_write(CFG_PROPORTIONAL_GAIN, {8'($urandom), kp});
        cfg_write(CFG_DEADZONE_DEGREES, {8'($urandom), dz});
        cfg_write(CFG_RUDDER_LOW_LIMIT, {8'($urandom), lo});
        cfg_write(CFG_RUDDER_HIGH_LIMIT, {8'($urandom), hi});
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly a plausible compass track near the filtered heading, with targets around
    // the deadzone edge; the rest is wild samples, NaNs and out-of-range targets.
    task automatic send_random_sample();
        logic [15:0] raw;
        logic        is_number;
        logic [8:0]  target;
        int          pick;
        int          dz;
        int          cur;
        int          span;
        int          off;
        dz        = int'(cmd_check.deadzone);
        cur       = cmd_check.current_heading();
        is_number = ($urandom_range(0, 9) != 0);

        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            raw = 16'($urandom_range(int'(SAMPLE_FULL_TURN), 65535));
        end else if (pick < 40) begin
            raw = 16'($urandom_range(0, int'(SAMPLE_FULL_TURN) - 1));
        end else begin
            span = 20 * 128;
            off  = int'($urandom_range(0, 2 * span)) - span;
            raw  = 16'(((cur * 128 + off) % int'(SAMPLE_FULL_TURN) + int'(SAMPLE_FULL_TURN))
                       % int'(SAMPLE_FULL_TURN));
        end

        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            target = 9'($urandom_range(0, 511));
        end else if (pick < 35) begin
            // right on the deadzone edge, or one degree inside it
            off = dz - int'($urandom_range(0, 1));
            if (off < 0)
                off = 0;
            if ($urandom_range(0, 1))
                off = -off;
            target = heading_offset(off);
        end else if (pick < 70) begin
            off    = int'($urandom_range(0, 2 * (dz + 3))) - (dz + 3);
            target = heading_offset(off);
        end else begin
            off    = int'($urandom_range(0, 360)) - 180;
            target = heading_offset(off);
        end
        send_sample(raw, is_number, target);
    endtask

    task automatic run_random(int count);
        repeat (count) send_random_sample();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings. NaN before the filter is loaded: error from zero.
        send_sample(16'd12345, 1'b0, 9'd0);
        send_sample(16'd0, 1'b0, 9'd100);      // clamp to 180, then the high limit
        send_sample(16'hFFFF, 1'b0, 9'd300);   // error wraps negative, clamp to 0 then low limit
        send_sample(16'd0, 1'b1, 9'd0);        // first valid sample loads the filter
        send_sample(16'd46079, 1'b1, 9'd1);    // largest legal sample, filter wraps past north
        send_sample(SAMPLE_FULL_TURN, 1'b1, 9'd359);
        send_sample(16'hFFFF, 1'b1, 9'd511);   // sample above a full turn, target at its top
        send_sample(16'd23040, 1'b1, 9'd180);
        send_sample(16'd1, 1'b1, 9'd360);
        send_sample(16'h8000, 1'b0, 9'd256);
        // NaN keeps the filter still, so these hit exact errors
        send_sample(16'h7FFF, 1'b0, heading_offset(1));
        send_sample(16'h7FFF, 1'b0, heading_offset(-1));
        send_sample(16'h5555, 1'b0, heading_offset(2));
        send_sample(16'h5555, 1'b0, heading_offset(-2));
        send_sample(16'hAAAA, 1'b0, heading_offset(180));
        send_sample(16'hAAAA, 1'b0, heading_offset(-180));
        send_sample(16'h1234, 1'b0, heading_offset(179));
        send_sample(16'h1234, 1'b0, heading_offset(-179));
        send_sample(16'h2AAA, 1'b1, heading_offset(10));
        send_sample(16'h5555, 1'b1, heading_offset(-40));

        // Top gains, no deadzone, full rudder range, and a stretch without idling
        apply_settings(16'hFFFF, 8'd255, 8'd0, 8'd0, 8'd180);
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
        run_random(120);
        send_quiet = 1'b0;
        recv_quiet = 1'b0;

        // Slowest filter, zero rudder gain: rudder holds centre
        apply_settings(16'd1, 8'd0, 8'd1, 8'd0, 8'd180);
        run_random(80);

        // Writes to unused indexes must change nothing
        wait_idle();
        cfg_write(CFG_SPARE_FIRST, 16'($urandom));
        cfg_write(CFG_SPARE_LAST, 16'($urandom));
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        apply_settings(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 10)), 8'($urandom_range(0, 90)),
                       8'($urandom_range(90, 180)));
        run_random(120);

        // Low limit above the high limit: the low limit wins
        apply_settings(16'd32768, 8'd16, 8'd5, 8'd100, 8'd60);
        run_random(80);

        // Widest deadzone: only an error of exactly 180 gets through
        apply_settings(16'd655, 8'd40, 8'd180, 8'd20, 8'd170);
        run_random(60);

        // Receiver holds off for a long stretch while the sender keeps offering
        apply_settings(16'd20000, 8'd200, 8'd3, 8'd30, 8'd150);
        send_quiet = 1'b1;
        hold_armed = 1'b1;
        run_random(150);
        send_quiet = 1'b0;

        repeat (2) begin
            apply_settings(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 12)), 8'($urandom_range(0, 180)),
                           8'($urandom_range(0, 180)));
            run_random(110);
        end

        wait_idle();
        if (cmd_check.expected_cmds.size() != 0)
            cmd_check.report_mismatch($sformatf("%0d expected commands never arrived",
                                                cmd_check.expected_cmds.size()));
        if (cmd_check.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
